// ----- rtl/core/bdq_pkg.sv -----
// Package for the bounded deque: sizes, operation and status codes,
// and the request struct that drives the word store.
// No dependencies.
package bdq_pkg;

    // Capacity of the list, 2 to 64 words
    localparam int CAPACITY = 64;
    localparam int SLOT_W   = $clog2(CAPACITY);

    // Field widths
    localparam int WORD_W = 32;
    localparam int KIND_W = 3;
    localparam int CNT_W  = 7;
    localparam int POS_W  = 6;
    localparam int STAT_W = 2;

    // Width of the ring slot sum: front slot plus an offset
    localparam int SUM_W = CNT_W + 1;

    // Operation codes
    localparam logic [KIND_W-1:0] KIND_PUSH_FRONT   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_BACK    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_REMOVE_FRONT = 3'd2;
    localparam logic [KIND_W-1:0] KIND_REMOVE_BACK  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_INSERT       = 3'd4;
    localparam logic [KIND_W-1:0] KIND_DUMP         = 3'd5;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

    // Store access request: one write port, one read port
    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] waddr;
        logic [WORD_W-1:0] wdata;
        logic              re;
        logic [SLOT_W-1:0] raddr;
    } store_req_t;

endpackage

// ----- rtl/core/bdq_cmd_if.sv -----
// Command channel of the deque: valid/ready plus one operation.
// Depends on bdq_pkg.
interface bdq_cmd_if;
    logic                                  valid;
    logic                                  ready;
    logic [bdq_pkg::KIND_W-1:0]            kind;
    logic signed [bdq_pkg::WORD_W-1:0]     value;
    logic [bdq_pkg::CNT_W-1:0]             count;
    logic [bdq_pkg::POS_W-1:0]             position;

    modport source (output valid, output kind, output value, output count,
                    output position, input ready);
    modport sink   (input valid, input kind, input value, input count,
                    input position, output ready);
endinterface

// ----- rtl/core/bdq_rsp_if.sv -----
// Response channel of the deque: valid/ready plus one result beat.
// Depends on bdq_pkg.
interface bdq_rsp_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [bdq_pkg::WORD_W-1:0]     word;
    logic [bdq_pkg::STAT_W-1:0]            status;
    logic [bdq_pkg::CNT_W-1:0]             stored;
    logic                                  last;

    modport source (output valid, output word, output status, output stored,
                    output last, input ready);
    modport sink   (input valid, input word, input status, input stored,
                    input last, output ready);
endinterface

// ----- rtl/core/bdq_slot.sv -----
// Shared ring slot unit: maps an offset from the front to a store slot.
// Depends on bdq_pkg.
module bdq_slot (
    input  logic [bdq_pkg::SLOT_W-1:0] front,
    input  logic [bdq_pkg::CNT_W-1:0]  offset,
    output logic [bdq_pkg::SLOT_W-1:0] slot
);

    logic [bdq_pkg::SUM_W-1:0] sum;
    logic [bdq_pkg::SUM_W-1:0] wrapped;

    // front + offset stays below twice the capacity: one compare and subtract
    always_comb
    begin
        sum     = bdq_pkg::SUM_W'(front) + bdq_pkg::SUM_W'(offset);
        wrapped = sum;
        if (sum >= bdq_pkg::SUM_W'(bdq_pkg::CAPACITY))
        begin
            wrapped = sum - bdq_pkg::SUM_W'(bdq_pkg::CAPACITY);
        end
        slot = wrapped[bdq_pkg::SLOT_W-1:0];
    end

endmodule

// ----- rtl/core/bdq_store.sv -----
// Word store of the deque: one write port, one read port, registered read.
// Depends on bdq_pkg.
module bdq_store (
    input  logic                       clk,
    input  bdq_pkg::store_req_t        req,
    output logic [bdq_pkg::WORD_W-1:0] rdata
);

    logic [bdq_pkg::WORD_W-1:0] mem [bdq_pkg::CAPACITY];
    logic [bdq_pkg::WORD_W-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    // Read port; data holds until the next read
    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/bdq_ctrl.sv -----
// Sequencer of the deque: front/count state, the shared slot unit, the
// insert shift loop, the dump walk and the response register.
// Depends on bdq_pkg, bdq_cmd_if, bdq_rsp_if, bdq_slot.
module bdq_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    bdq_cmd_if.sink                    cmd,
    bdq_rsp_if.source                  rsp,
    output bdq_pkg::store_req_t        req,
    input  logic [bdq_pkg::WORD_W-1:0] rdata
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_EXEC     = 3'd1;
    localparam logic [2:0] S_SHIFT_RD = 3'd2;
    localparam logic [2:0] S_SHIFT_WR = 3'd3;
    localparam logic [2:0] S_DUMP_RD  = 3'd4;
    localparam logic [2:0] S_DUMP_OUT = 3'd5;
    localparam logic [2:0] S_RESP     = 3'd6;

    localparam int CNT_W  = bdq_pkg::CNT_W;
    localparam int SLOT_W = bdq_pkg::SLOT_W;

    logic [2:0]                  state_reg, state_next;
    logic [SLOT_W-1:0]           front_reg, front_next;
    logic [CNT_W-1:0]            held_reg, held_next;
    logic [bdq_pkg::KIND_W-1:0]  kind_reg, kind_next;
    logic [bdq_pkg::WORD_W-1:0]  value_reg, value_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic [bdq_pkg::POS_W-1:0]   pos_reg, pos_next;
    logic [CNT_W-1:0]            idx_reg, idx_next;
    logic [SLOT_W-1:0]           addr_reg, addr_next;
    logic [SLOT_W-1:0]           rd_addr_reg, rd_addr_next;
    logic [bdq_pkg::STAT_W-1:0]  status_reg, status_next;

    logic                        out_valid_reg, out_valid_next;
    logic [bdq_pkg::WORD_W-1:0]  out_word_reg, out_word_next;
    logic [bdq_pkg::STAT_W-1:0]  out_status_reg, out_status_next;
    logic [CNT_W-1:0]            out_stored_reg, out_stored_next;
    logic                        out_last_reg, out_last_next;

    logic                        out_free;
    logic                        full;
    logic [CNT_W-1:0]            rm_n;
    logic [CNT_W-1:0]            held_left;
    logic [CNT_W-1:0]            pos_next_idx;
    logic [CNT_W-1:0]            offset;
    logic [SLOT_W-1:0]           slot;
    logic                        dump_last;

    // Shared ring slot unit
    bdq_slot u_slot (
        .front  (front_reg),
        .offset (offset),
        .slot   (slot)
    );

    assign cmd.ready    = (state_reg == S_IDLE);
    assign out_free     = !out_valid_reg || rsp.ready;
    assign full         = (held_reg >= CNT_W'(bdq_pkg::CAPACITY));
    assign rm_n         = (count_reg > held_reg) ? held_reg : count_reg;
    assign held_left    = held_reg - rm_n;
    assign pos_next_idx = CNT_W'(pos_reg) + CNT_W'(1);
    assign dump_last    = ((idx_reg + CNT_W'(1)) == held_reg);

    // Offset fed to the slot unit in each state
    always_comb
    begin
        offset = '0;
        unique case (state_reg)
            S_EXEC:
            begin
                case (kind_reg)
                    bdq_pkg::KIND_PUSH_FRONT:   offset = CNT_W'(bdq_pkg::CAPACITY - 1);
                    bdq_pkg::KIND_REMOVE_FRONT: offset = rm_n;
                    default:                    offset = held_reg;
                endcase
            end
            S_SHIFT_RD: offset = idx_reg - CNT_W'(1);
            S_DUMP_RD:  offset = idx_reg;
            default:    offset = '0;
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        front_next      = front_reg;
        held_next       = held_reg;
        kind_next       = kind_reg;
        value_next      = value_reg;
        count_next      = count_reg;
        pos_next        = pos_reg;
        idx_next        = idx_reg;
        addr_next       = addr_reg;
        rd_addr_next    = rd_addr_reg;
        status_next     = status_reg;
        req             = '0;

        // response register drains on its own
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_word_next   = out_word_reg;
        out_status_next = out_status_reg;
        out_stored_next = out_stored_reg;
        out_last_next   = out_last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    kind_next  = cmd.kind;
                    value_next = cmd.value;
                    count_next = cmd.count;
                    pos_next   = cmd.position;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                status_next = bdq_pkg::ST_OK;
                state_next  = S_RESP;
                unique case (kind_reg) inside
                    bdq_pkg::KIND_PUSH_FRONT:
                    begin
                        if (full)
                        begin
                            status_next = bdq_pkg::ST_FULL;
                        end
                        else
                        begin
                            req.we     = 1'b1;
                            req.waddr  = slot;
                            req.wdata  = value_reg;
                            front_next = slot;
                            held_next  = held_reg + CNT_W'(1);
                        end
                    end
                    bdq_pkg::KIND_PUSH_BACK:
                    begin
                        if (full)
                        begin
                            status_next = bdq_pkg::ST_FULL;
                        end
                        else
                        begin
                            req.we    = 1'b1;
                            req.waddr = slot;
                            req.wdata = value_reg;
                            held_next = held_reg + CNT_W'(1);
                        end
                    end
                    bdq_pkg::KIND_REMOVE_FRONT, bdq_pkg::KIND_REMOVE_BACK:
                    begin
                        if (held_reg == '0)
                        begin
                            status_next = bdq_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            if (count_reg > held_reg)
                            begin
                                status_next = bdq_pkg::ST_EMPTY;
                            end
                            if (kind_reg == bdq_pkg::KIND_REMOVE_FRONT)
                            begin
                                front_next = slot;
                            end
                            held_next = held_left;
                            if (held_left == '0)
                            begin
                                front_next = '0;
                            end
                        end
                    end
                    bdq_pkg::KIND_INSERT:
                    begin
                        if (full)
                        begin
                            status_next = bdq_pkg::ST_FULL;
                        end
                        else if (CNT_W'(pos_reg) >= held_reg)
                        begin
                            status_next = bdq_pkg::ST_RANGE;
                        end
                        else
                        begin
                            // slot one past the tail is the first target
                            addr_next  = slot;
                            idx_next   = held_reg;
                            state_next = S_SHIFT_RD;
                        end
                    end
                    bdq_pkg::KIND_DUMP:
                    begin
                        if (held_reg == '0)
                        begin
                            status_next = bdq_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            idx_next   = '0;
                            state_next = S_DUMP_RD;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            // Insert: move words up one slot until the gap sits just past the position
            S_SHIFT_RD:
            begin
                if (idx_reg > pos_next_idx)
                begin
                    req.re       = 1'b1;
                    req.raddr    = slot;
                    rd_addr_next = slot;
                    state_next   = S_SHIFT_WR;
                end
                else
                begin
                    req.we     = 1'b1;
                    req.waddr  = addr_reg;
                    req.wdata  = value_reg;
                    held_next  = held_reg + CNT_W'(1);
                    state_next = S_RESP;
                end
            end

            S_SHIFT_WR:
            begin
                req.we     = 1'b1;
                req.waddr  = addr_reg;
                req.wdata  = rdata;
                addr_next  = rd_addr_reg;
                idx_next   = idx_reg - CNT_W'(1);
                state_next = S_SHIFT_RD;
            end

            // Dump: one read, then one beat per word
            S_DUMP_RD:
            begin
                req.re     = 1'b1;
                req.raddr  = slot;
                state_next = S_DUMP_OUT;
            end

            S_DUMP_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_word_next   = rdata;
                    out_status_next = bdq_pkg::ST_OK;
                    out_stored_next = held_reg;
                    out_last_next   = dump_last;
                    idx_next        = idx_reg + CNT_W'(1);
                    state_next      = dump_last ? S_IDLE : S_DUMP_RD;
                end
            end

            S_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_word_next   = '0;
                    out_status_next = status_reg;
                    out_stored_next = held_reg;
                    out_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            front_reg     <= '0;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            held_reg      <= held_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload and loop registers
    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        value_reg      <= value_next;
        count_reg      <= count_next;
        pos_reg        <= pos_next;
        idx_reg        <= idx_next;
        addr_reg       <= addr_next;
        rd_addr_reg    <= rd_addr_next;
        status_reg     <= status_next;
        out_word_reg   <= out_word_next;
        out_status_reg <= out_status_next;
        out_stored_reg <= out_stored_next;
        out_last_reg   <= out_last_next;
    end

    assign rsp.valid  = out_valid_reg;
    assign rsp.word   = out_word_reg;
    assign rsp.status = out_status_reg;
    assign rsp.stored = out_stored_reg;
    assign rsp.last   = out_last_reg;

endmodule

// ----- rtl/core/bounded_deque_with_insert_top.sv -----
// Top level of the bounded deque with insert: sequencer plus word store.
// Depends on bdq_pkg, bdq_cmd_if, bdq_rsp_if, bdq_ctrl, bdq_store.
//
// Holds up to CAPACITY signed 32-bit words as a ring-buffered deque. A command
// beat is taken only while the sequencer is idle; each command runs to the end
// before the next one is taken, while the last response beat may still sit in
// the output register. With the output register free, push, remove, a
// rejected insert and an empty dump pass through the execute state and then
// the response state, where the response beat loads; the sequencer then
// returns to idle for the next command. In an insert the words above the
// position move up one slot at a time, each a read and then a write through
// the store's registered read port and single write port, both addressed by
// the shared slot adder. Dump reads each stored word from the store and then
// loads it into the response register, one beat per word. A beat still held
// in the output register stalls the sequencer until it is taken.
module bounded_deque_with_insert_top (
    input logic       clk,
    input logic       rst_n,
    bdq_cmd_if.sink   cmd,
    bdq_rsp_if.source rsp
);

    bdq_pkg::store_req_t        req;
    logic [bdq_pkg::WORD_W-1:0] rdata;

    bdq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .rsp   (rsp),
        .req   (req),
        .rdata (rdata)
    );

    bdq_store u_store (
        .clk   (clk),
        .req   (req),
        .rdata (rdata)
    );

endmodule

// ----- tb/sv/bounded_deque_with_insert_top_tb.sv -----
// Self-checking testbench for bounded_deque_with_insert_top: random and directed deque
// operations, with every response beat checked against a queue-based predictor.
// Depends on bdq_pkg, bdq_cmd_if, bdq_rsp_if and the RTL of the block.

// One response beat as the block should give it
typedef struct packed {
    logic signed [bdq_pkg::WORD_W-1:0] word;
    logic [bdq_pkg::STAT_W-1:0]        status;
    logic [bdq_pkg::CNT_W-1:0]         stored;
    logic                              last;
} deque_beat_t;

// Keeps its own copy of the list and the beats still owed by the block
class deque_scoreboard;
    logic signed [bdq_pkg::WORD_W-1:0] list_words[$];
    deque_beat_t                       owed_beats[$];
    int                                errors;

    function new();
        errors = 0;
    endfunction

    function int held();
        return list_words.size();
    endfunction

    function int pending();
        return owed_beats.size();
    endfunction

    local function void owe(logic signed [bdq_pkg::WORD_W-1:0] word,
                            logic [bdq_pkg::STAT_W-1:0] status, logic last);
        deque_beat_t b;
        b.word   = word;
        b.status = status;
        b.stored = bdq_pkg::CNT_W'(list_words.size());
        b.last   = last;
        owed_beats.push_back(b);
    endfunction

    // Apply one accepted command to the list and queue the beats it owes
    function void note_command(logic [bdq_pkg::KIND_W-1:0] kind,
                               logic signed [bdq_pkg::WORD_W-1:0] value,
                               logic [bdq_pkg::CNT_W-1:0] count,
                               logic [bdq_pkg::POS_W-1:0] position);
        logic [bdq_pkg::STAT_W-1:0] status;
        int n;
        int pos;
        status = bdq_pkg::ST_OK;
        n      = int'(count);
        pos    = int'(position);
        case (kind)
            bdq_pkg::KIND_PUSH_FRONT, bdq_pkg::KIND_PUSH_BACK:
            begin
                if (list_words.size() >= bdq_pkg::CAPACITY)
                    status = bdq_pkg::ST_FULL;
                else if (kind == bdq_pkg::KIND_PUSH_FRONT)
                    list_words.push_front(value);
                else
                    list_words.push_back(value);
            end
            bdq_pkg::KIND_REMOVE_FRONT, bdq_pkg::KIND_REMOVE_BACK:
            begin
                if (list_words.size() == 0)
                    status = bdq_pkg::ST_EMPTY;
                else
                begin
                    // overlong removal empties the list and flags it
                    if (n > list_words.size())
                    begin
                        n      = list_words.size();
                        status = bdq_pkg::ST_EMPTY;
                    end
                    repeat (n)
                    begin
                        if (kind == bdq_pkg::KIND_REMOVE_FRONT)
                            void'(list_words.pop_front());
                        else
                            void'(list_words.pop_back());
                    end
                end
            end
            bdq_pkg::KIND_INSERT:
            begin
                // full is checked before the position
                if (list_words.size() >= bdq_pkg::CAPACITY)
                    status = bdq_pkg::ST_FULL;
                else if (pos >= list_words.size())
                    status = bdq_pkg::ST_RANGE;
                else if (pos + 1 == list_words.size())
                    list_words.push_back(value);
                else
                    list_words.insert(pos + 1, value);
            end
            bdq_pkg::KIND_DUMP:
            begin
                if (list_words.size() == 0)
                    owe('0, bdq_pkg::ST_EMPTY, 1'b1);
                else
                    foreach (list_words[i])
                        owe(list_words[i], bdq_pkg::ST_OK, i == list_words.size() - 1);
                return;
            end
            default:
                return;     // unused kinds: no beat, no change
        endcase
        owe('0, status, 1'b1);
    endfunction

    // Compare one accepted response beat with the oldest owed beat
    function void check_result(deque_beat_t got);
        deque_beat_t exp;
        if (owed_beats.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected beat: word %0d status %0d stored %0d last %0b",
                     $time, got.word, got.status, got.stored, got.last);
            return;
        end
        exp = owed_beats.pop_front();
        if (got.word !== exp.word || got.status !== exp.status ||
            got.stored !== exp.stored || got.last !== exp.last)
        begin
            errors++;
            $display("%0t: beat mismatch: expected word %0d status %0d stored %0d last %0b, %s",
                     $time, exp.word, exp.status, exp.stored, exp.last,
                     $sformatf("got word %0d status %0d stored %0d last %0b",
                               got.word, got.status, got.stored, got.last));
        end
    endfunction
endclass

module bounded_deque_with_insert_top_tb;
    import bdq_pkg::*;

    localparam int IDLE_LIMIT  = 5000;
    localparam int DRAIN_TIME  = 300;
    localparam int RANDOM_OPS  = 250;

    // Kinds the block ignores
    localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

    logic clk;
    logic rst_n;
    bit   quiet;        // no idling on either side while set
    int   ops_sent;
    int   idle_cycles;

    deque_scoreboard sb;

    bdq_cmd_if cmd ();
    bdq_rsp_if rsp ();

    bounded_deque_with_insert_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd.sink),
        .rsp   (rsp.source)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Gap length: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [WORD_W-1:0] pick_value();
        case ($urandom_range(0, 11))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Drive one command beat after a random gap and wait for its handshake
    task automatic send_op(input logic [KIND_W-1:0] kind,
                           input logic signed [WORD_W-1:0] value,
                           input logic [CNT_W-1:0] count,
                           input logic [POS_W-1:0] position);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            cmd.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd.valid    <= 1'b1;
        cmd.kind     <= kind;
        cmd.value    <= value;
        cmd.count    <= count;
        cmd.position <= position;
        do
            @(posedge clk);
        while (!cmd.ready);
        sb.note_command(kind, value, count, position);
        ops_sent++;
    endtask

    // Hold the command side until every owed beat has come back
    task automatic wait_drained();
        cmd.valid <= 1'b0;
        while (sb.pending() > 0)
            @(posedge clk);
    endtask

    // Random mix of operations, mostly well-formed for the current list
    task automatic run_mixed(input int n);
        int r;
        int held;
        repeat (n)
        begin
            r    = $urandom_range(0, 99);
            held = sb.held();
            if (r < 20)
                send_op(KIND_PUSH_FRONT, pick_value(), CNT_W'($urandom), POS_W'($urandom));
            else if (r < 40)
                send_op(KIND_PUSH_BACK, pick_value(), CNT_W'($urandom), POS_W'($urandom));
            else if (r < 60)
                send_op(KIND_INSERT, pick_value(), CNT_W'($urandom),
                        (held > 0 && $urandom_range(0, 4) != 0) ?
                        POS_W'($urandom_range(0, held - 1)) : POS_W'($urandom_range(0, 63)));
            else if (r < 80)
                send_op((r < 70) ? KIND_REMOVE_FRONT : KIND_REMOVE_BACK, $urandom,
                        ($urandom_range(0, 3) != 0) ?
                        CNT_W'($urandom_range(0, held + 1)) : CNT_W'($urandom_range(0, 127)),
                        POS_W'($urandom));
            else if (r < 94)
                send_op(KIND_DUMP, $urandom, CNT_W'($urandom), POS_W'($urandom));
            else
                send_op(($urandom_range(0, 1) != 0) ? KIND_SPARE_HI : KIND_SPARE_LO,
                        $urandom, CNT_W'($urandom), POS_W'($urandom));
        end
    endtask

    // Fill the list to capacity, hit it while full, dump, then empty it
    task automatic run_fill();
        int held;
        while (sb.held() < CAPACITY)
        begin
            held = sb.held();
            if (held > 1 && $urandom_range(0, 4) == 0)
                send_op(KIND_INSERT, pick_value(), CNT_W'($urandom),
                        POS_W'($urandom_range(0, held - 1)));
            else
                send_op($urandom_range(0, 1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT,
                        pick_value(), CNT_W'($urandom), POS_W'($urandom));
        end
        send_op(KIND_PUSH_FRONT, pick_value(), CNT_W'($urandom), POS_W'($urandom));
        send_op(KIND_PUSH_BACK, pick_value(), CNT_W'($urandom), POS_W'($urandom));
        send_op(KIND_INSERT, pick_value(), CNT_W'($urandom), POS_W'($urandom));
        send_op(KIND_DUMP, $urandom, CNT_W'($urandom), POS_W'($urandom));
        wait_drained();
        send_op($urandom_range(0, 1) ? KIND_REMOVE_BACK : KIND_REMOVE_FRONT,
                $urandom, CNT_W'($urandom_range(CAPACITY, 127)), POS_W'($urandom));
    endtask

    // Response side: check accepted beats, stall ready at random
    initial
    begin
        int          rest;
        deque_beat_t got;
        rest      = 0;
        rsp.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp.valid && rsp.ready)
            begin
                got.word   = rsp.word;
                got.status = rsp.status;
                got.stored = rsp.stored;
                got.last   = rsp.last;
                sb.check_result(got);
            end
            if (!rst_n || rest > 0)
            begin
                rsp.ready <= 1'b0;
                if (rest > 0)
                    rest--;
            end
            else
            begin
                rsp.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    rest = pick_gap();
            end
        end
    end

    // Watchdog: ends the run when no beat moves on either channel for too long
    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((cmd.valid && cmd.ready) || (rsp.valid && rsp.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Reset, directed cases, random episodes, drain
    initial
    begin
        sb           = new();
        quiet        = 1'b0;
        ops_sent     = 0;
        rst_n        <= 1'b0;
        cmd.valid    <= 1'b0;
        cmd.kind     <= KIND_PUSH_FRONT;
        cmd.value    <= '0;
        cmd.count    <= '0;
        cmd.position <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list corner cases
        send_op(KIND_DUMP, '0, '0, '0);
        send_op(KIND_REMOVE_FRONT, '0, 7'd5, '0);
        send_op(KIND_REMOVE_BACK, '1, 7'd0, '1);
        send_op(KIND_INSERT, 32'sd9, '0, 6'd0);
        // field extremes, insert after the last word and in the middle
        send_op(KIND_PUSH_BACK, 32'sh7FFF_FFFF, '0, '0);
        send_op(KIND_PUSH_FRONT, 32'sh8000_0000, '1, '1);
        send_op(KIND_PUSH_BACK, -32'sd1, '0, '0);
        send_op(KIND_INSERT, '0, '0, 6'd2);
        send_op(KIND_INSERT, 32'sh5555_AAAA, '0, 6'd0);
        send_op(KIND_INSERT, 32'sh2AAA_5555, '0, 6'd63);
        send_op(KIND_REMOVE_FRONT, '0, 7'd0, '0);
        send_op(KIND_DUMP, '0, '0, '0);
        // unused kinds are ignored
        send_op(KIND_SPARE_LO, '1, '1, '1);
        send_op(KIND_SPARE_HI, '1, '1, '1);
        send_op(KIND_REMOVE_BACK, '0, 7'd1, '0);
        send_op(KIND_DUMP, '0, '0, '0);
        // overlong removals
        send_op(KIND_REMOVE_FRONT, '0, 7'd127, '0);
        send_op(KIND_PUSH_FRONT, 32'sd1, '0, '0);
        send_op(KIND_PUSH_FRONT, 32'sd2, '0, '0);
        send_op(KIND_REMOVE_BACK, '0, 7'd64, '0);
        send_op(KIND_DUMP, '0, '0, '0);

        // random part
        run_fill();
        while (ops_sent < RANDOM_OPS)
        begin
            quiet = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 19) == 0)
                run_fill();
            else
                run_mixed(20);
        end

        quiet = 1'b0;
        wait_drained();
        repeat (DRAIN_TIME) @(posedge clk);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
